// File: rtl/core/keuf_pkg.sv
// Package for the Kruskal edge union-find unit: widths, payload and control types.
`default_nettype none
package keuf_pkg;

    // Largest graph the parent table holds
    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;

    // Fixed field widths
    localparam int VERT_W   = 10;
    localparam int WEIGHT_W = 32;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] VC_RESET = CFG_W'(1024);

    typedef struct packed {
        logic                first_edge;
        logic [VERT_W-1:0]   from_vertex;
        logic [VERT_W-1:0]   to_vertex;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic                chosen;
        logic [VERT_W-1:0]   out_from;
        logic [VERT_W-1:0]   out_to;
        logic [WEIGHT_W-1:0] out_weight;
        logic                tree_complete;
        logic                bad_vertex;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // take the input item
        logic clr;    // write one identity entry of the sweep
        logic eval;   // range check, completion check, start the first walk
        logic find;   // compare fetched parent with the current vertex
        logic halve;  // path halving write and step
        logic emit;   // load the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;  // sweep is at the last entry
        logic skip;      // edge is bad or tree already complete
        logic root_hit;  // current vertex is its own parent
        logic phase_b;   // walking from to_vertex
        logic out_free;  // output register can take a result
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/core/keuf_dp.sv
// Datapath: parent table memory, config register, counters, walk registers and output register.
`default_nettype none
module keuf_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire keuf_pkg::t_cmd                i_cmd,
    output keuf_pkg::t_sts                     o_sts,
    input  wire keuf_pkg::t_in_item            i_in_item,
    output keuf_pkg::t_out_item                o_out_item,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [keuf_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int ADDR_W = keuf_pkg::ADDR_W;
    localparam int CNT_W  = keuf_pkg::CNT_W;

    // Parent table
    logic [ADDR_W-1:0] mem [keuf_pkg::MAX_VERTICES];
    logic [ADDR_W-1:0] r_rd_data;

    logic [keuf_pkg::CFG_W-1:0] r_vc;
    keuf_pkg::t_in_item         r_item;
    logic [ADDR_W-1:0]          r_clr_cnt;
    logic [ADDR_W-1:0]          r_cnt;
    logic                       r_fin;
    logic                       r_bad;
    logic                       r_took;
    logic [ADDR_W-1:0]          r_v;
    logic [ADDR_W-1:0]          r_ra;
    logic                       r_phase;
    keuf_pkg::t_out_item        r_out;
    logic                       r_out_valid;

    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  nm1;
    logic              bad;
    logic              fin_now;
    logic              hit;
    logic              merge;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [ADDR_W-1:0] wd;
    logic [ADDR_W-1:0] from_idx;
    logic [ADDR_W-1:0] to_idx;

    // Effective vertex count, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_vc == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(r_vc) > 32'(keuf_pkg::MAX_VERTICES)) begin
            n_eff = CNT_W'(keuf_pkg::MAX_VERTICES);
        end else begin
            n_eff = CNT_W'(r_vc);
        end
    end

    assign nm1      = n_eff - CNT_W'(1);
    assign bad      = (CNT_W'(r_item.from_vertex) >= n_eff) ||
                      (CNT_W'(r_item.to_vertex) >= n_eff);
    assign fin_now  = r_fin || (CNT_W'(r_cnt) >= nm1);
    assign hit      = (r_rd_data == r_v);
    assign merge    = i_cmd.find && hit && r_phase && (r_ra != r_v);
    assign from_idx = ADDR_W'(r_item.from_vertex);
    assign to_idx   = ADDR_W'(r_item.to_vertex);

    // Memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_rd_data;
        we      = 1'b0;
        wa      = r_v;
        wd      = r_rd_data;
        if (i_cmd.clr) begin
            we = 1'b1;
            wa = r_clr_cnt;
            wd = r_clr_cnt;
        end else if (i_cmd.eval) begin
            rd_en   = 1'b1;
            rd_addr = from_idx;
        end else if (i_cmd.find) begin
            if (hit && !r_phase) begin
                rd_en   = 1'b1;
                rd_addr = to_idx;
            end else if (!hit) begin
                rd_en   = 1'b1;
                rd_addr = r_rd_data;
            end
            if (merge) begin
                we = 1'b1;
                wa = r_v;
                wd = r_ra;
            end
        end else if (i_cmd.halve) begin
            // parent[v] <= grandparent, then step to it
            we      = 1'b1;
            wa      = r_v;
            wd      = r_rd_data;
            rd_en   = 1'b1;
            rd_addr = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc        <= keuf_pkg::VC_RESET;
            r_clr_cnt   <= '0;
            r_cnt       <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vc <= i_cfg_data;
            end
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (i_cmd.load && i_in_item.first_edge) begin
                r_cnt <= '0;
                r_fin <= 1'b0;
            end else if (i_cmd.eval) begin
                r_fin <= fin_now;
            end else if (merge) begin
                r_cnt <= r_cnt + ADDR_W'(1);
                if ((CNT_W'(r_cnt) + CNT_W'(1)) >= nm1) begin
                    r_fin <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, walk and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.eval) begin
            r_bad   <= bad;
            r_took  <= 1'b0;
            r_v     <= from_idx;
            r_phase <= 1'b0;
        end
        if (i_cmd.find && hit && !r_phase) begin
            r_ra    <= r_v;
            r_v     <= to_idx;
            r_phase <= 1'b1;
        end
        if (merge) begin
            r_took <= 1'b1;
        end
        if (i_cmd.halve) begin
            r_v <= r_rd_data;
        end
        if (i_cmd.emit) begin
            r_out.chosen        <= r_took;
            r_out.out_from      <= r_item.from_vertex;
            r_out.out_to        <= r_item.to_vertex;
            r_out.out_weight    <= r_item.edge_weight;
            r_out.tree_complete <= r_fin;
            r_out.bad_vertex    <= r_bad;
        end
    end

    assign o_sts.clr_last = &r_clr_cnt;
    assign o_sts.skip     = fin_now || bad;
    assign o_sts.root_hit = hit;
    assign o_sts.phase_b  = r_phase;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_item  = r_out;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

// File: rtl/core/keuf_ctrl.sv
// Controller: sequences table sweep, root walks, merge and result hand-off.
`default_nettype none
module keuf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_first_edge,
    output logic             o_in_ready,
    input  wire keuf_pkg::t_sts i_sts,
    output keuf_pkg::t_cmd   o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_FIND  = 6'b001000,
        S_HALVE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   in_acc;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_pend  = 1'b0;
                    n_state = r_pend ? S_EVAL : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_first_edge) begin
                        n_pend  = 1'b1;
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.skip ? S_DONE : S_FIND;
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                if (!i_sts.root_hit) begin
                    n_state = S_HALVE;
                end else if (i_sts.phase_b) begin
                    n_state = S_DONE;
                end
            end
            S_HALVE: begin
                o_cmd.halve = 1'b1;
                n_state     = S_FIND;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_pend  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

// File: rtl/core/kruskal_edge_union_find_unit.sv
// Top level of the Kruskal edge union-find unit: controller plus datapath.
// An accepted item passes eval and the find and halve steps of both root walks, then waits to emit;
// a bad edge, or one that arrives after completion, skips both walks and goes straight to emit.
// Items are taken one at a time; the input reopens as the result is registered, and an output
// stall holds the item back until then. A first-edge item adds an identity sweep of all 1024
// table entries. Synchronous active-low reset starts the same sweep.
`default_nettype none
module kruskal_edge_union_find_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire keuf_pkg::t_in_item     i_in_item,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output keuf_pkg::t_out_item         o_out_item,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [keuf_pkg::CFG_W-1:0]   i_cfg_data
);

    keuf_pkg::t_cmd cmd;
    keuf_pkg::t_sts sts;

    // Sequencer
    keuf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_first_edge (i_in_item.first_edge),
        .o_in_ready   (o_in_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // Table, counters and output register
    keuf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

`ifndef SYNTHESIS
    // One item at a time: an accepted item closes the input until its result is out
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    // A bad endpoint never enters the tree
    a_bad_not_chosen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.bad_vertex) |-> !o_out_item.chosen)
        else $error("bad vertex edge reported as chosen");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

// File: sim/kruskal_edge_union_find_unit_tb.sv
// Self-checking testbench for the Kruskal edge union-find unit, with its own union-find predictor.
module kruskal_edge_union_find_unit_tb;

    localparam int  MAX_VERTICES     = keuf_pkg::MAX_VERTICES;
    localparam int  CFG_W            = keuf_pkg::CFG_W;
    localparam int  VERT_W           = keuf_pkg::VERT_W;
    localparam int  WEIGHT_W         = keuf_pkg::WEIGHT_W;
    localparam int  SEND_TAIL_CYCLES = 40;
    localparam int  HOLD_AFTER       = 60;     // results seen before the long receiver hold-off
    localparam int  HOLD_CYCLES      = 400;
    localparam int  PHASE_ITEMS      = 180;
    localparam longint LIMIT_TIME    = 64'd12 * 64'd8_000_000;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    keuf_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    keuf_pkg::t_out_item out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data  = '0;

    // Predictor state: forest, edges taken so far, completion flag, vertex count register
    int                  forest_parent [MAX_VERTICES];
    int                  tree_edges;
    bit                  tree_done;
    logic [CFG_W-1:0]    graph_size;

    // Items waiting to be offered, and results still owed by the block
    keuf_pkg::t_in_item  pending_edges [$];
    keuf_pkg::t_out_item owed_results  [$];
    int                  edges_queued  = 0;
    int                  mismatches    = 0;
    int unsigned         results_seen  = 0;

    // Idling state of both sides
    bit                  sending    = 1'b0;
    int                  send_gap   = 0;
    int                  send_streak = 0;
    bit                  send_calm  = 1'b0;
    int                  take_wait  = 0;
    int                  take_streak = 0;
    bit                  take_calm  = 1'b1;
    int                  hold_left  = 0;
    bit                  hold_done  = 1'b0;

    int                  random_sizes [10] = '{1024, 2, 17, 1, 300, 64, 2047, 5, 1000, 9};

    kruskal_edge_union_find_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Register value clamped to 1..MAX_VERTICES
    function automatic int effective_size(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_VERTICES) return MAX_VERTICES;
        return int'(v);
    endfunction

    function automatic void reset_forest();
        for (int i = 0; i < MAX_VERTICES; i++) forest_parent[i] = i;
        tree_edges = 0;
        tree_done  = 1'b0;
    endfunction

    // Root lookup with path halving; every visited node is pointed at its grandparent
    function automatic int find_root(int v);
        int steps;
        steps = 0;
        while (v != forest_parent[v] && steps < MAX_VERTICES) begin
            forest_parent[v] = forest_parent[forest_parent[v]];
            v = forest_parent[v];
            steps++;
        end
        return v;
    endfunction

    function automatic keuf_pkg::t_out_item predict_edge(keuf_pkg::t_in_item it);
        keuf_pkg::t_out_item r;
        int        n;
        int        ra;
        int        rb;
        bit        bad;
        if (it.first_edge) reset_forest();
        n   = effective_size(graph_size);
        bad = (int'(it.from_vertex) >= n) || (int'(it.to_vertex) >= n);
        // a count lowered mid-graph or a one-vertex graph is complete at once
        if (tree_edges >= n - 1) tree_done = 1'b1;
        r.chosen = 1'b0;
        if (!tree_done && !bad) begin
            ra = find_root(int'(it.from_vertex));
            rb = find_root(int'(it.to_vertex));
            if (ra != rb) begin
                forest_parent[rb] = ra;
                r.chosen = 1'b1;
                tree_edges++;
                if (tree_edges >= n - 1) tree_done = 1'b1;
            end
        end
        r.out_from      = it.from_vertex;
        r.out_to        = it.to_vertex;
        r.out_weight    = it.edge_weight;
        r.tree_complete = tree_done;
        r.bad_vertex    = bad;
        return r;
    endfunction

    // Per-item idle draw; alternates stretches of random gaps with stretches of none
    function automatic int pick_wait(inout int streak, inout bit calm);
        if (streak == 0) begin
            calm   = !calm;
            streak = $urandom_range(10, 60);
        end
        streak--;
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Sender: offers queued items with random gaps between them
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            sending  = 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                owed_results.push_back(predict_edge(in_item));
                sending = 1'b0;
            end
            if (!sending) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_edges.size() != 0) begin
                    in_item  <= pending_edges.pop_front();
                    sending  = 1'b1;
                    send_gap = pick_wait(send_streak, send_calm);
                end
            end
            in_valid <= sending;
        end
    end

    // Receiver: checks each result against the oldest prediction
    always @(posedge clk) begin
        keuf_pkg::t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            take_wait = 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, out_item);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    compare_field("chosen", 32'(want.chosen), 32'(out_item.chosen));
                    compare_field("out_from", 32'(want.out_from), 32'(out_item.out_from));
                    compare_field("out_to", 32'(want.out_to), 32'(out_item.out_to));
                    compare_field("out_weight", want.out_weight, out_item.out_weight);
                    compare_field("tree_complete", 32'(want.tree_complete),
                                  32'(out_item.tree_complete));
                    compare_field("bad_vertex", 32'(want.bad_vertex),
                                  32'(out_item.bad_vertex));
                end
                take_wait = pick_wait(take_streak, take_calm);
            end
            out_ready <= (take_wait == 0) && (hold_left == 0);
            if (take_wait > 0) take_wait--;
        end
    end

    // One long receiver hold-off so the block backs up and stalls its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen == HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    task automatic queue_edge(bit first, int a, int b, logic [WEIGHT_W-1:0] w);
        keuf_pkg::t_in_item it;
        it.first_edge  = first;
        it.from_vertex = VERT_W'(a);
        it.to_vertex   = VERT_W'(b);
        it.edge_weight = w;
        pending_edges.push_back(it);
        edges_queued++;
    endtask

    // One graph: mostly spanning growth and in-range edges, some noise
    task automatic queue_random_graph(int n);
        int                  grown;
        int                  len;
        int                  a;
        int                  b;
        int                  pick;
        int                  tmp;
        bit                  first;
        logic [WEIGHT_W-1:0] w;
        grown = 1;
        w     = $urandom_range(0, 1000);
        len   = (n < 40) ? 2 * n + $urandom_range(1, 8) : $urandom_range(30, 60);
        for (int i = 0; i < len; i++) begin
            pick  = $urandom_range(0, 99);
            first = (i == 0);
            w     = w + $urandom_range(0, 50);
            if (pick < 60 && grown < n) begin
                a = $urandom_range(0, grown - 1);
                b = grown;
                grown++;
                if ($urandom_range(0, 1)) begin
                    tmp = a;
                    a   = b;
                    b   = tmp;
                end
            end else if (pick < 90) begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
            end else begin
                a     = $urandom_range(0, MAX_VERTICES - 1);
                b     = $urandom_range(0, MAX_VERTICES - 1);
                w     = $urandom;
                first = first || ($urandom_range(0, 19) == 0);
            end
            queue_edge(first, a, b, w);
        end
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_edges.size() != 0 || sending || owed_results.size() != 0);
    endtask

    // Register writes only once every owed result is back
    task automatic write_vertex_count(logic [CFG_W-1:0] v);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        graph_size = v;
    endtask

    initial begin
        reset_forest();
        graph_size = keuf_pkg::VC_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Full-size count: field extremes, repeat edge, self loop
        write_vertex_count(11'd2047);
        queue_edge(1'b1, 0, 1023, 32'h0000_0000);
        queue_edge(1'b0, 1023, 0, 32'hFFFF_FFFF);
        queue_edge(1'b0, 5, 5, $urandom);
        queue_edge(1'b0, 1023, 1023, $urandom);

        // Zero count acts as one vertex: always complete
        write_vertex_count(11'd0);
        queue_edge(1'b0, 0, 0, $urandom);
        queue_edge(1'b0, 1, 0, $urandom);
        queue_edge(1'b1, 0, 0, $urandom);

        // Six vertices: bad endpoints, edges inside a component, completion
        write_vertex_count(11'd6);
        queue_edge(1'b1, 0, 1, 32'd10);
        queue_edge(1'b0, 1, 2, 32'd11);
        queue_edge(1'b0, 2, 3, 32'd12);
        queue_edge(1'b0, 3, 6, 32'd13);
        queue_edge(1'b0, 6, 0, 32'd14);
        queue_edge(1'b0, 0, 3, 32'd15);
        queue_edge(1'b0, 3, 2, 32'd16);
        queue_edge(1'b0, 4, 5, 32'd17);
        queue_edge(1'b0, 5, 0, 32'd18);
        queue_edge(1'b0, 4, 1, 32'd19);

        // Count lowered part way through a graph
        write_vertex_count(11'd4);
        queue_edge(1'b1, 0, 1, 32'd20);
        queue_edge(1'b0, 2, 3, 32'd21);
        write_vertex_count(11'd3);
        queue_edge(1'b0, 1, 3, 32'd22);
        queue_edge(1'b1, 2, 1, 32'd23);
        queue_edge(1'b0, 1, 0, 32'd24);

        // Random graphs over a spread of sizes
        foreach (random_sizes[i]) begin
            int target;
            write_vertex_count(CFG_W'(random_sizes[i]));
            target = edges_queued + PHASE_ITEMS;
            while (edges_queued < target)
                queue_random_graph(effective_size(CFG_W'(random_sizes[i])));
        end

        wait_drained();
        repeat (SEND_TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("[kruskal_edge_union_find_unit] OK");
        else
            $display("[kruskal_edge_union_find_unit] ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_TIME);
        $display("[kruskal_edge_union_find_unit] ERROR");
        $finish;
    end

endmodule
